### hdl/stap_pkg.sv
`default_nettype none
package stap_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam int COS_FRAC_BITS = 30;

    typedef enum logic [1:0] {
        CMD_LOAD_ARMOR  = 2'd0,
        CMD_LOAD_CENTER = 2'd1,
        CMD_ADVANCE     = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_VEL_X    = 2'd0,
        REG_VEL_Y    = 2'd1,
        REG_VEL_Z    = 2'd2,
        REG_YAW_RATE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         armor_index;
        logic signed [15:0] armor_angle;
        logic [17:0]        armor_radius;
        logic signed [23:0] armor_height;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic [31:0]        timestamp;
    } word_t;

    typedef struct packed {
        logic [1:0]         out_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] yaw;
        logic               last;
    } result_t;

    function automatic logic signed [15:0] atan_entry(input logic [3:0] i);
        logic signed [15:0] r;
        unique case (i)
            4'd0: r = 16'sd8192;
            4'd1: r = 16'sd4836;
            4'd2: r = 16'sd2555;
            4'd3: r = 16'sd1297;
            4'd4: r = 16'sd651;
            4'd5: r = 16'sd326;
            4'd6: r = 16'sd163;
            4'd7: r = 16'sd81;
            4'd8: r = 16'sd41;
            4'd9: r = 16'sd20;
            4'd10: r = 16'sd10;
            4'd11: r = 16'sd5;
            4'd12: r = 16'sd3;
            4'd13: r = 16'sd1;
            4'd14: r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/stap_front.sv
`default_nettype none
module stap_front
    import stap_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire word_t in_word,
    output word_t      q_word,
    output logic       q_valid,
    input  wire logic  q_take
);

    localparam int DEPTH = 2;

    word_t      mem_reg [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    // Commands with no effect are dropped here and never reach the back part.
    assign full    = (count_reg == 2'(DEPTH));
    assign do_push = push && !full && (in_word.cmd != CMD_NONE);
    assign q_valid = (count_reg != 2'd0);
    assign do_pop  = q_valid && q_take;
    assign q_word  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

### hdl/stap_back.sv
`default_nettype none
module stap_back
    import stap_pkg::*;
#(
    parameter int PLATE_COUNT = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire word_t        q_word,
    input  wire logic         q_valid,
    output logic              q_take,
    input  wire logic signed [23:0] vel_x,
    input  wire logic signed [23:0] vel_y,
    input  wire logic signed [23:0] vel_z,
    input  wire logic signed [23:0] yaw_rate,
    output result_t           res,
    output logic              res_valid,
    input  wire logic         res_take
);

    localparam int PW = (PLATE_COUNT > 1) ? $clog2(PLATE_COUNT) : 1;
    localparam int TIME_BITS = 16;
    localparam int RS = COS_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DT, S_MUL, S_CENTRE, S_PLATE, S_CORDIC, S_PROD, S_POS, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [23:0] cx_reg, cy_reg;
    logic [31:0] last_time_reg;
    logic signed [15:0] ang_reg [PLATE_COUNT];
    logic [17:0]        rad_reg [PLATE_COUNT];
    logic signed [23:0] hgt_reg [PLATE_COUNT];
    logic signed [31:0] dt_reg;
    logic signed [55:0] mx_reg, my_reg, mz_reg, mw_reg;
    logic [PW-1:0] pl_reg;
    logic [3:0] step_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [17:0] z_reg;
    logic flip_reg;
    logic signed [52:0] px_reg, py_reg;
    result_t res_reg;
    logic valid_reg;

    logic signed [55:0] rx, ry, rz, rw;
    logic signed [33:0] dx, dy;
    logic signed [17:0] za;
    logic signed [15:0] new_ang;
    logic signed [63:0] sum_x, sum_y;
    logic signed [33:0] cxv, cyv;

    function automatic logic signed [55:0] rnd(input logic signed [55:0] v);
        return (v + (56'sd1 <<< (TIME_BITS - 1))) >>> TIME_BITS;
    endfunction

    assign rx = rnd(mx_reg);
    assign ry = rnd(my_reg);
    assign rz = rnd(mz_reg);
    assign rw = rnd(mw_reg);
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign new_ang = ang_reg[pl_reg] + rw[15:0];
    assign za = 18'(new_ang);
    assign cxv = flip_reg ? -x_reg : x_reg;
    assign cyv = flip_reg ? -y_reg : y_reg;
    assign sum_x = 64'(cx_reg) + 64'((px_reg + (53'sd1 <<< (RS - 1))) >>> RS);
    assign sum_y = 64'(cy_reg) + 64'((py_reg + (53'sd1 <<< (RS - 1))) >>> RS);

    assign q_take    = (state_reg == S_IDLE) && q_valid;
    assign res       = res_reg;
    assign res_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && !valid_reg)
            res_reg <= '{out_index: 2'(pl_reg), pos_x: sat24(sum_x), pos_y: sat24(sum_y),
                         pos_z: hgt_reg[pl_reg], yaw: ang_reg[pl_reg],
                         last: (32'(pl_reg) == PLATE_COUNT - 1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            last_time_reg <= '0;
            for (int i = 0; i < PLATE_COUNT; i++)
            begin
                ang_reg[i] <= '0;
                rad_reg[i] <= '0;
                hgt_reg[i] <= '0;
            end
            dt_reg   <= '0;
            mx_reg   <= '0;
            my_reg   <= '0;
            mz_reg   <= '0;
            mw_reg   <= '0;
            pl_reg   <= '0;
            step_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            flip_reg <= 1'b0;
            px_reg   <= '0;
            py_reg   <= '0;
        end
        else
        begin
            if (valid_reg && res_take)
                valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        unique case (cmd_t'(q_word.cmd))
                            CMD_LOAD_ARMOR:
                            begin
                                if (32'(q_word.armor_index) < PLATE_COUNT)
                                begin
                                    ang_reg[PW'(q_word.armor_index)] <= q_word.armor_angle;
                                    rad_reg[PW'(q_word.armor_index)] <= q_word.armor_radius;
                                    hgt_reg[PW'(q_word.armor_index)] <= q_word.armor_height;
                                end
                            end
                            CMD_LOAD_CENTER:
                            begin
                                cx_reg        <= q_word.center_x;
                                cy_reg        <= q_word.center_y;
                                last_time_reg <= q_word.timestamp;
                            end
                            CMD_ADVANCE:
                            begin
                                dt_reg        <= q_word.timestamp - last_time_reg;
                                last_time_reg <= q_word.timestamp;
                                state_reg     <= S_DT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_DT:
                begin
                    mx_reg    <= vel_x * dt_reg;
                    my_reg    <= vel_y * dt_reg;
                    mz_reg    <= vel_z * dt_reg;
                    mw_reg    <= yaw_rate * dt_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cx_reg    <= sat24(64'(cx_reg) + 64'(rx));
                    cy_reg    <= sat24(64'(cy_reg) + 64'(ry));
                    pl_reg    <= '0;
                    state_reg <= S_CENTRE;
                end
                S_CENTRE:
                begin
                    mz_reg    <= 56'(rz);
                    state_reg <= S_PLATE;
                end
                S_PLATE:
                begin
                    ang_reg[pl_reg] <= new_ang;
                    hgt_reg[pl_reg] <= sat24(64'(hgt_reg[pl_reg]) + 64'(mz_reg));
                    x_reg    <= 34'(CORDIC_GAIN_Q30);
                    y_reg    <= '0;
                    step_reg <= '0;
                    if (za > 18'sd16384)
                    begin
                        z_reg    <= za - 18'sd32768;
                        flip_reg <= 1'b1;
                    end
                    else if (za < -18'sd16384)
                    begin
                        z_reg    <= za + 18'sd32768;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg    <= za;
                        flip_reg <= 1'b0;
                    end
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (!z_reg[17])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - 18'(atan_entry(step_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + 18'(atan_entry(step_reg));
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(CORDIC_STEPS - 1))
                        state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    px_reg    <= $signed({1'b0, rad_reg[pl_reg]}) * cxv;
                    py_reg    <= $signed({1'b0, rad_reg[pl_reg]}) * cyv;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!valid_reg)
                    begin
                        valid_reg <= 1'b1;
                        if (32'(pl_reg) == PLATE_COUNT - 1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            pl_reg    <= pl_reg + PW'(1);
                            state_reg <= S_PLATE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/stap_outq.sv
`default_nettype none
module stap_outq
    import stap_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t in_res,
    input  wire logic    in_valid,
    output logic         in_take,
    output result_t      out_res,
    output logic         empty,
    input  wire logic    pop
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign in_take = (count_reg != 2'd2);
    assign do_push = in_valid && in_take;
    assign empty   = (count_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign out_res = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= in_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

### hdl/spinning_target_armor_predictor.sv
// A load item takes effect when the idle back part takes it from the input queue.
// An advance updates the centre, then yields one result per plate in plate order,
// and holds the back part until the result for the last plate has been issued.
// Throughput is set by the 16-step shared CORDIC iteration, run once per plate,
// while results are taken. A two-word input queue and a two-word result queue decouple both sides.
// Reset is asynchronous, active low, and zeroes all but queue and result data.
`default_nettype none
module spinning_target_armor_predictor
    import stap_pkg::*;
#(
    parameter int PLATE_COUNT = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         cmd,
    input  wire logic [1:0]         armor_index,
    input  wire logic signed [15:0] armor_angle,
    input  wire logic [17:0]        armor_radius,
    input  wire logic signed [23:0] armor_height,
    input  wire logic signed [23:0] center_x,
    input  wire logic signed [23:0] center_y,
    input  wire logic [31:0]        timestamp,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              out_index,
    output logic signed [23:0]      pos_x,
    output logic signed [23:0]      pos_y,
    output logic signed [23:0]      pos_z,
    output logic signed [15:0]      yaw,
    output logic                    last,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);

    word_t   in_word, q_word;
    logic    q_valid, q_take, res_valid, res_take;
    result_t res, out_res;
    logic signed [23:0] vel_x_reg, vel_y_reg, vel_z_reg, yaw_rate_reg;

    assign in_word = '{cmd: cmd, armor_index: armor_index, armor_angle: armor_angle,
                       armor_radius: armor_radius, armor_height: armor_height,
                       center_x: center_x, center_y: center_y, timestamp: timestamp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
            vel_z_reg    <= '0;
            yaw_rate_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_VEL_X:    vel_x_reg    <= cfg_data;
                REG_VEL_Y:    vel_y_reg    <= cfg_data;
                REG_VEL_Z:    vel_z_reg    <= cfg_data;
                REG_YAW_RATE: yaw_rate_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    stap_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .q_word(q_word), .q_valid(q_valid), .q_take(q_take)
    );

    stap_back #(.PLATE_COUNT(PLATE_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_word(q_word), .q_valid(q_valid), .q_take(q_take),
        .vel_x(vel_x_reg), .vel_y(vel_y_reg), .vel_z(vel_z_reg), .yaw_rate(yaw_rate_reg),
        .res(res), .res_valid(res_valid), .res_take(res_take)
    );

    stap_outq u_outq (
        .clk(clk), .rst_n(rst_n), .in_res(res), .in_valid(res_valid), .in_take(res_take),
        .out_res(out_res), .empty(empty), .pop(pop)
    );

    assign out_index = out_res.out_index;
    assign pos_x     = out_res.pos_x;
    assign pos_y     = out_res.pos_y;
    assign pos_z     = out_res.pos_z;
    assign yaw       = out_res.yaw;
    assign last      = out_res.last;

endmodule
`default_nettype wire

### hdl/stap_checker.sv
`default_nettype none
module stap_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic empty,
    input wire logic pop,
    input wire logic last,
    input wire logic [1:0] out_index
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("Result word dropped while stalled.");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (out_index == 2'd3))
        else $error("Last flag on a plate other than the final one.");

    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> (empty || out_index == $past(out_index) + 2'd1))
        else $error("Plate results out of order.");

    a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last) |=> (empty || out_index == 2'd0))
        else $error("Advance did not start at the first plate.");

endmodule

bind spinning_target_armor_predictor stap_checker u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .last(last), .out_index(out_index)
);
`default_nettype wire
